// ===== design/sida_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the controller state type, BCD shifter control types and ASCII constants.
// No dependencies.
`default_nettype none

package sida_pkg;

    // Default and limits of the input integer width
    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int VALUE_PORT_WIDTH    = 64;
    localparam int CHAR_WIDTH          = 8;

    // ASCII codes
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } sida_state_t;

    // BCD shift register operations
    typedef enum logic [1:0] {
        BCD_HOLD,
        BCD_CLEAR,
        BCD_DABBLE,
        BCD_DIGIT
    } bcd_op_t;

    // Control bundle from the controller to the BCD shift register
    typedef struct packed {
        bcd_op_t op;
        logic    bit_in;
    } bcd_ctl_t;

endpackage : sida_pkg

`default_nettype wire

// ===== design/sida_bcd.sv =====
// BCD digit shift register with serial double dabble.
// One binary bit enters per dabble cycle; digits leave one per digit shift, MSD first.
// Depends on sida_pkg.
`default_nettype none

module sida_bcd #(
    parameter int NUM_DIGITS = 20
) (
    input  wire logic                clk,
    input  wire sida_pkg::bcd_ctl_t  ctl,
    output logic [3:0]               top_digit
);
    import sida_pkg::*;

    localparam int BCD_WIDTH = 4 * NUM_DIGITS;

    logic [BCD_WIDTH-1:0] bcd_reg;
    logic [BCD_WIDTH-1:0] bcd_next;
    logic [BCD_WIDTH-1:0] adj;

    // Add 3 to every digit of 5 or more, each digit on its own
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Next value by operation
    always_comb
    begin
        unique case (ctl.op)
            BCD_HOLD:   bcd_next = bcd_reg;
            BCD_CLEAR:  bcd_next = '0;
            BCD_DABBLE: bcd_next = {adj[BCD_WIDTH-2:0], ctl.bit_in};
            BCD_DIGIT:  bcd_next = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
            default:    bcd_next = bcd_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

endmodule : sida_bcd

`default_nettype wire

// ===== design/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Controller, magnitude shifter and output register; instantiates sida_bcd.
// Depends on sida_pkg and sida_bcd.
//
// Takes one two's complement integer (low VALUE_WIDTH bits of value) and sends its
// decimal text as ASCII characters, most significant first: '-' for negative
// values, no leading zeros, '0' for zero, last_char set on the final character.
// The most negative value converts exactly. One number is converted at a time.
// The input is registered, then the bit-serial double dabble loop shifts in all
// VALUE_WIDTH magnitude bits. Leading zero digits are dropped one per cycle, and
// then the skip state is left. Each character is then sent when the output slot
// is free (out_valid low or out_ready high); a negative value adds a sign state
// before the digits. Receiver stalls hold the output and delay the next number.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [sida_pkg::VALUE_PORT_WIDTH-1:0] value,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [sida_pkg::CHAR_WIDTH-1:0]             character,
    output logic                                        last_char
);
    import sida_pkg::*;

    // Enough digits for the magnitude 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    sida_state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]   mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_WIDTH-1:0]    char_reg, char_next;
    logic                     last_reg, last_next;

    logic [VALUE_WIDTH-1:0]   raw;
    logic [VALUE_WIDTH-1:0]   raw_mag;
    logic                     slot_free;
    logic [3:0]               top_digit;
    bcd_ctl_t                 bcd_ctl;

    // Magnitude as unsigned within VALUE_WIDTH bits
    assign raw     = value[VALUE_WIDTH-1:0];
    assign raw_mag = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    sida_bcd #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .clk       (clk),
        .ctl       (bcd_ctl),
        .top_digit (top_digit)
    );

    // Next state, datapath control and output register load
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bcd_ctl.op     = BCD_HOLD;
        bcd_ctl.bit_in = mag_reg[VALUE_WIDTH-1];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next     = raw_mag;
                    neg_next     = raw[VALUE_WIDTH-1];
                    bit_cnt_next = '0;
                    bcd_ctl.op   = BCD_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // One magnitude bit into the BCD register per cycle, MSB first
                bcd_ctl.op   = BCD_DABBLE;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, always keep the last digit
                if (top_digit == 4'd0 && dig_cnt_reg != DIG_CNT_W'(1))
                begin
                    bcd_ctl.op   = BCD_DIGIT;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + {4'd0, top_digit};
                    last_next      = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_ctl.op     = BCD_DIGIT;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

    // An accepted number always starts conversion next cycle
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV))
        else $error("accepted number did not start conversion");

    // The sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == ASCII_MINUS) |-> !last_char)
        else $error("minus sign flagged as last character");

    // Digit count never runs out while digits remain to be sent
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> (dig_cnt_reg != '0))
        else $error("digit count exhausted during output");

    // A new character is only loaded into a free output slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && (state_reg == ST_EMIT || state_reg == ST_SIGN))
        |=> ($stable(character) && $stable(last_char)))
        else $error("pending character overwritten");

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
